// ===== hw/rtl/script_byte_tokenizer_macros.svh =====
// assertion macros for the tokenizer modules, used by stb_queue
// no dependencies; expects clk and rst in the including module
`ifndef SCRIPT_BYTE_TOKENIZER_MACROS_SVH
`define SCRIPT_BYTE_TOKENIZER_MACROS_SVH

// same-cycle implication
`define STB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// next-cycle implication
`define STB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

// ===== hw/rtl/stb_pkg.sv =====
// shared constants and byte classes for the script byte tokenizer
// no dependencies
package stb_pkg;

  localparam int DEF_OFFSET_BITS = 32;
  localparam int DEF_LENGTH_BITS = 16;
  localparam int DEF_DEPTH_BITS  = 8;

  localparam int MAX_TOKENS = 4;
  localparam int CNT_BITS   = 3;
  localparam int KIND_BITS  = 4;

  localparam logic [3:0] KIND_INVALID = 4'd0;
  localparam logic [3:0] KIND_IDENT   = 4'd1;
  localparam logic [3:0] KIND_NUMBER  = 4'd2;
  localparam logic [3:0] KIND_STRING  = 4'd3;
  localparam logic [3:0] KIND_BAR     = 4'd4;
  localparam logic [3:0] KIND_STMT    = 4'd5;
  localparam logic [3:0] KIND_LPAREN  = 4'd6;
  localparam logic [3:0] KIND_RPAREN  = 4'd7;
  localparam logic [3:0] KIND_LBRACK  = 4'd8;
  localparam logic [3:0] KIND_RBRACK  = 4'd9;
  localparam logic [3:0] KIND_LBRACE  = 4'd10;
  localparam logic [3:0] KIND_RBRACE  = 4'd11;
  localparam logic [3:0] KIND_END     = 4'd12;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0B) ||
               (b == 8'h0C);
  endfunction

  function automatic logic ends_ident(input logic [7:0] b);
    ends_ident = is_blank(b) || (b == CH_NL) || (b == CH_LPAREN) ||
                 (b == CH_RPAREN) || (b == CH_LBRACK) || (b == CH_RBRACK) ||
                 (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_BSL);
  endfunction

endpackage

// ===== hw/rtl/stb_front.sv =====
// lexer front: takes one byte a cycle while q_full is low, updates the lexer
// state, builds the bundle of up to four tokens that byte closes; uses stb_pkg
module stb_front import stb_pkg::*; #(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int LENGTH_BITS = DEF_LENGTH_BITS,
  parameter int DEPTH_BITS  = DEF_DEPTH_BITS,
  parameter int BW = CNT_BITS + MAX_TOKENS * (KIND_BITS + OFFSET_BITS + LENGTH_BITS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    text_byte,
  input  logic          final_byte,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          q_full,
  output logic          push,
  output logic [BW-1:0] push_data
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_BSL     = 4'd1;
  localparam logic [3:0] M_HASH    = 4'd2;
  localparam logic [3:0] M_LINE    = 4'd3;
  localparam logic [3:0] M_BLOCK   = 4'd4;
  localparam logic [3:0] M_SIGN    = 4'd5;
  localparam logic [3:0] M_IDENT   = 4'd6;
  localparam logic [3:0] M_INT     = 4'd7;
  localparam logic [3:0] M_FRAC    = 4'd8;
  localparam logic [3:0] M_E       = 4'd9;
  localparam logic [3:0] M_ESIGN   = 4'd10;
  localparam logic [3:0] M_EXP     = 4'd11;
  localparam logic [3:0] M_STR     = 4'd12;
  localparam logic [3:0] M_STR_ESC = 4'd13;

  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

  logic [3:0]             mode, mode_next;
  logic [OFFSET_BITS-1:0] start, start_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [LENGTH_BITS-1:0] rlen, rlen_next;
  logic [1:0]             hcnt, hcnt_next;
  logic [DEPTH_BITS-1:0]  depth, depth_next;
  logic [7:0]             prior, prior_next;

  logic [MAX_TOKENS-1:0][KIND_BITS-1:0]   e_kind;
  logic [MAX_TOKENS-1:0][OFFSET_BITS-1:0] e_off;
  logic [MAX_TOKENS-1:0][LENGTH_BITS-1:0] e_len;
  logic [CNT_BITS-1:0]                    ecnt;
  logic                                   done;
  logic [OFFSET_BITS-1:0]                 p, q;
  logic [7:0]                             b;
  logic                                   accept;

  function automatic logic [LENGTH_BITS-1:0] grow(input logic [LENGTH_BITS-1:0] a,
                                                  input logic [2:0] n);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, a} + (LENGTH_BITS+1)'(n);
    grow = s[LENGTH_BITS] ? '1 : s[LENGTH_BITS-1:0];
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && (ecnt != '0);
  assign push_data = {ecnt, e_kind, e_off, e_len};

  always_comb begin
    mode_next  = mode;
    start_next = start;
    rlen_next  = rlen;
    hcnt_next  = hcnt;
    depth_next = depth;
    prior_next = prior;
    e_kind = '0;
    e_off  = '0;
    e_len  = '0;
    ecnt   = '0;
    done   = 1'b0;
    b = text_byte;
    p = pos;
    q = pos + OFFSET_BITS'(1);
    pos_next = q;

    case (mode_next)
      M_BSL: begin
        mode_next = M_IDLE;
        if (b == CH_NL) begin
          done = 1'b1;
        end else begin
          e_kind[ecnt[1:0]] = KIND_INVALID; e_off[ecnt[1:0]] = start_next;
          e_len[ecnt[1:0]] = LEN_ONE; ecnt = ecnt + 1'b1;
        end
      end
      M_SIGN: begin
        if (is_digit(b)) begin
          mode_next = M_INT; rlen_next = grow(rlen_next, 3'd1); done = 1'b1;
        end else begin
          mode_next = M_IDENT;
        end
      end
      M_E, M_ESIGN: begin
        if (is_digit(b)) begin
          rlen_next = grow(rlen_next, 3'(hcnt_next) + 3'd1);
          hcnt_next = '0; mode_next = M_EXP; done = 1'b1;
        end else if (mode_next == M_E && (b == CH_PLUS || b == CH_MINUS)) begin
          hcnt_next = hcnt_next + 2'd1; mode_next = M_ESIGN; done = 1'b1;
        end else begin
          // exponent mark not followed by a digit: back off
          e_kind[ecnt[1:0]] = KIND_NUMBER; e_off[ecnt[1:0]] = start_next;
          e_len[ecnt[1:0]] = rlen_next; ecnt = ecnt + 1'b1;
          start_next = p - OFFSET_BITS'(hcnt_next);
          rlen_next  = LENGTH_BITS'(hcnt_next);
          hcnt_next  = '0;
          mode_next  = M_IDENT;
        end
      end
      M_INT, M_FRAC, M_EXP: begin
        if (is_digit(b)) begin
          rlen_next = grow(rlen_next, 3'd1); done = 1'b1;
        end else if (mode_next == M_INT && b == CH_DOT) begin
          mode_next = M_FRAC; rlen_next = grow(rlen_next, 3'd1); done = 1'b1;
        end else if (mode_next != M_EXP && (b == CH_LOW_E || b == CH_UP_E)) begin
          hcnt_next = 2'd1; mode_next = M_E; done = 1'b1;
        end else begin
          e_kind[ecnt[1:0]] = KIND_NUMBER; e_off[ecnt[1:0]] = start_next;
          e_len[ecnt[1:0]] = rlen_next; ecnt = ecnt + 1'b1;
          mode_next = M_IDLE;
        end
      end
      M_HASH: begin
        done = 1'b1;
        if (b == CH_LBRACK) begin
          mode_next = M_BLOCK; depth_next = DEPTH_BITS'(1); prior_next = '0;
          rlen_next = grow(rlen_next, 3'd1);
        end else if (b == CH_NL) begin
          e_kind[ecnt[1:0]] = KIND_STMT; e_off[ecnt[1:0]] = p;
          e_len[ecnt[1:0]] = LEN_ONE; ecnt = ecnt + 1'b1;
          mode_next = M_IDLE;
        end else begin
          mode_next = M_LINE; rlen_next = grow(rlen_next, 3'd1);
        end
      end
      M_LINE: begin
        done = 1'b1;
        if (b == CH_NL) begin
          e_kind[ecnt[1:0]] = KIND_STMT; e_off[ecnt[1:0]] = p;
          e_len[ecnt[1:0]] = LEN_ONE; ecnt = ecnt + 1'b1;
          mode_next = M_IDLE;
        end else begin
          rlen_next = grow(rlen_next, 3'd1);
        end
      end
      M_BLOCK: begin
        done = 1'b1;
        rlen_next = grow(rlen_next, 3'd1);
        if (prior_next == CH_HASH && b == CH_LBRACK) begin
          if (depth_next != '1) depth_next = depth_next + 1'b1;
          prior_next = '0;
        end else if (prior_next == CH_RBRACK && b == CH_HASH) begin
          prior_next = '0;
          if (depth_next != '0) depth_next = depth_next - 1'b1;
          if (depth_next == '0) begin
            e_kind[ecnt[1:0]] = KIND_STMT; e_off[ecnt[1:0]] = p;
            e_len[ecnt[1:0]] = LEN_ONE; ecnt = ecnt + 1'b1;
            mode_next = M_IDLE;
          end
        end else begin
          prior_next = b;
        end
      end
      M_STR: begin
        done = 1'b1;
        if (b == CH_QUOTE) begin
          e_kind[ecnt[1:0]] = KIND_STRING; e_off[ecnt[1:0]] = start_next;
          e_len[ecnt[1:0]] = rlen_next; ecnt = ecnt + 1'b1;
          mode_next = M_IDLE;
        end else begin
          rlen_next = grow(rlen_next, 3'd1);
          if (b == CH_BSL) mode_next = M_STR_ESC;
        end
      end
      M_STR_ESC: begin
        done = 1'b1;
        rlen_next = grow(rlen_next, 3'd1);
        mode_next = M_STR;
      end
      M_IDLE, M_IDENT: begin
      end
      default: begin
        mode_next = M_IDLE;
      end
    endcase

    if (!done && mode_next == M_IDENT) begin
      if (ends_ident(b)) begin
        e_kind[ecnt[1:0]] = KIND_IDENT; e_off[ecnt[1:0]] = start_next;
        e_len[ecnt[1:0]] = rlen_next; ecnt = ecnt + 1'b1;
        mode_next = M_IDLE;
      end else begin
        rlen_next = grow(rlen_next, 3'd1);
        done = 1'b1;
      end
    end

    if (!done && mode_next == M_IDLE) begin
      start_next = p;
      rlen_next  = LEN_ONE;
      if (!is_blank(b)) begin
        case (b)
          CH_BSL:  mode_next = M_BSL;
          CH_HASH: mode_next = M_HASH;
          CH_NL, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE,
          CH_BAR: begin
            case (b)
              CH_NL:     e_kind[ecnt[1:0]] = KIND_STMT;
              CH_LPAREN: e_kind[ecnt[1:0]] = KIND_LPAREN;
              CH_RPAREN: e_kind[ecnt[1:0]] = KIND_RPAREN;
              CH_LBRACK: e_kind[ecnt[1:0]] = KIND_LBRACK;
              CH_RBRACK: e_kind[ecnt[1:0]] = KIND_RBRACK;
              CH_LBRACE: e_kind[ecnt[1:0]] = KIND_LBRACE;
              CH_RBRACE: e_kind[ecnt[1:0]] = KIND_RBRACE;
              default:   e_kind[ecnt[1:0]] = KIND_BAR;
            endcase
            e_off[ecnt[1:0]] = p; e_len[ecnt[1:0]] = LEN_ONE; ecnt = ecnt + 1'b1;
          end
          CH_QUOTE: begin
            start_next = q; rlen_next = '0; mode_next = M_STR;
          end
          CH_PLUS, CH_MINUS: mode_next = M_SIGN;
          default: mode_next = is_digit(b) ? M_INT : M_IDENT;
        endcase
      end
    end

    if (final_byte) begin
      // close whatever is open, then the end token
      case (mode_next)
        M_BSL: begin
          e_kind[ecnt[1:0]] = KIND_INVALID; e_off[ecnt[1:0]] = start_next;
          e_len[ecnt[1:0]] = LEN_ONE; ecnt = ecnt + 1'b1;
        end
        M_HASH, M_LINE, M_BLOCK: begin
          e_kind[ecnt[1:0]] = KIND_INVALID; e_off[ecnt[1:0]] = start_next;
          e_len[ecnt[1:0]] = rlen_next; ecnt = ecnt + 1'b1;
        end
        M_SIGN, M_IDENT: begin
          e_kind[ecnt[1:0]] = KIND_IDENT; e_off[ecnt[1:0]] = start_next;
          e_len[ecnt[1:0]] = rlen_next; ecnt = ecnt + 1'b1;
        end
        M_INT, M_FRAC, M_EXP: begin
          e_kind[ecnt[1:0]] = KIND_NUMBER; e_off[ecnt[1:0]] = start_next;
          e_len[ecnt[1:0]] = rlen_next; ecnt = ecnt + 1'b1;
        end
        M_E, M_ESIGN: begin
          e_kind[ecnt[1:0]] = KIND_NUMBER; e_off[ecnt[1:0]] = start_next;
          e_len[ecnt[1:0]] = rlen_next; ecnt = ecnt + 1'b1;
          e_kind[ecnt[1:0]] = KIND_IDENT; e_off[ecnt[1:0]] = q - OFFSET_BITS'(hcnt_next);
          e_len[ecnt[1:0]] = LENGTH_BITS'(hcnt_next); ecnt = ecnt + 1'b1;
        end
        default: begin
        end
      endcase
      e_kind[ecnt[1:0]] = KIND_END; e_off[ecnt[1:0]] = q;
      e_len[ecnt[1:0]] = '0; ecnt = ecnt + 1'b1;
      mode_next  = M_IDLE;
      start_next = '0;
      pos_next   = '0;
      rlen_next  = '0;
      hcnt_next  = '0;
      depth_next = '0;
      prior_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      start <= '0;
      pos   <= '0;
      rlen  <= '0;
      hcnt  <= '0;
      depth <= '0;
      prior <= '0;
    end else if (accept) begin
      mode  <= mode_next;
      start <= start_next;
      pos   <= pos_next;
      rlen  <= rlen_next;
      hcnt  <= hcnt_next;
      depth <= depth_next;
      prior <= prior_next;
    end
  end

endmodule

// ===== hw/rtl/stb_queue.sv =====
// two-entry queue of token bundles between lexer front and emitter
// uses stb_pkg and the tokenizer assertion macros
`include "script_byte_tokenizer_macros.svh"
module stb_queue import stb_pkg::*; #(
  parameter int BW = CNT_BITS + MAX_TOKENS * (KIND_BITS + DEF_OFFSET_BITS + DEF_LENGTH_BITS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [BW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output logic [BW-1:0] head_data
);

  logic [BW-1:0] slots [2];
  logic          wptr, rptr;
  logic [1:0]    cnt;

  assign full       = (cnt == 2'd2);
  assign head_valid = (cnt != 2'd0);
  assign head_data  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  `STB_ASSERT_IMP(a_cnt_range, 1'b1, cnt <= 2'd2)
  `STB_ASSERT_IMP(a_pop_nonempty, pop, head_valid)
  `STB_ASSERT_NXT(a_push_grows, push && !pop, cnt == $past(cnt) + 2'd1)
  `STB_ASSERT_IMP(a_ptr_match, cnt == 2'd0 || cnt == 2'd2, wptr == rptr)

endmodule

// ===== hw/rtl/stb_back.sv =====
// token emitter: walks the head bundle one token a cycle onto the output while out_stall is low
// depends on stb_pkg
module stb_back import stb_pkg::*; #(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int LENGTH_BITS = DEF_LENGTH_BITS,
  parameter int BW = CNT_BITS + MAX_TOKENS * (KIND_BITS + OFFSET_BITS + LENGTH_BITS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  logic [BW-1:0]          head_data,
  output logic                   pop,
  output logic [3:0]             token_kind,
  output logic [OFFSET_BITS-1:0] token_offset,
  output logic [LENGTH_BITS-1:0] token_length,
  output logic                   last_of_run,
  output logic                   out_valid,
  input  logic                   out_stall
);

  logic [MAX_TOKENS-1:0][KIND_BITS-1:0]   h_kind;
  logic [MAX_TOKENS-1:0][OFFSET_BITS-1:0] h_off;
  logic [MAX_TOKENS-1:0][LENGTH_BITS-1:0] h_len;
  logic [CNT_BITS-1:0]                    h_cnt;
  logic [1:0]                             idx;
  logic                                   taken;

  assign {h_cnt, h_kind, h_off, h_len} = head_data;

  assign out_valid    = head_valid;
  assign token_kind   = h_kind[idx];
  assign token_offset = h_off[idx];
  assign token_length = h_len[idx];
  assign last_of_run  = (CNT_BITS'(idx) + 1'b1 == h_cnt);
  assign taken        = out_valid && !out_stall;
  assign pop          = taken && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (taken) begin
      idx <= last_of_run ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ===== hw/rtl/script_byte_tokenizer.sv =====
// top level of the script byte tokenizer: lexer front, bundle queue, emitter
// depends on stb_pkg, stb_front, stb_queue, stb_back
//
//  channel | handshake             | payload
//  input   | in_valid / in_stall   | text_byte, final_byte
//  output  | out_valid / out_stall | token_kind, token_offset, token_length, last_of_run
//
// one byte is lexed per cycle while in_stall is low; the emitter sends a byte's tokens
// one per cycle while out_stall is low, holding the output for them; the two-entry queue
// absorbs that and in_stall rises only when both bundles are waiting
// reset (rst, synchronous) clears lexer state, offsets and queue at once
// final_byte returns offsets and lexer state to their reset values
module script_byte_tokenizer import stb_pkg::*; #(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int LENGTH_BITS = DEF_LENGTH_BITS,
  parameter int DEPTH_BITS  = DEF_DEPTH_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             text_byte,
  input  logic                   final_byte,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic [3:0]             token_kind,
  output logic [OFFSET_BITS-1:0] token_offset,
  output logic [LENGTH_BITS-1:0] token_length,
  output logic                   last_of_run,
  output logic                   out_valid,
  input  logic                   out_stall
);

  localparam int BW = CNT_BITS + MAX_TOKENS * (KIND_BITS + OFFSET_BITS + LENGTH_BITS);

  logic          push, pop, full, head_valid;
  logic [BW-1:0] push_data, head_data;

  stb_front #(
    .OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS),
    .DEPTH_BITS(DEPTH_BITS), .BW(BW)
  ) u_front (
    .clk(clk), .rst(rst), .text_byte(text_byte), .final_byte(final_byte),
    .in_valid(in_valid), .in_stall(in_stall), .q_full(full),
    .push(push), .push_data(push_data)
  );

  stb_queue #(.BW(BW)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .head_valid(head_valid), .head_data(head_data)
  );

  stb_back #(
    .OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS), .BW(BW)
  ) u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head_data(head_data),
    .pop(pop), .token_kind(token_kind), .token_offset(token_offset),
    .token_length(token_length), .last_of_run(last_of_run),
    .out_valid(out_valid), .out_stall(out_stall)
  );

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for script_byte_tokenizer: a scoreboard class with
// its own model of the lexer predicts the tokens of every accepted byte
// depends on stb_pkg and the tokenizer rtl
module tb_top;
  import stb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    LX_IDLE, LX_BSL, LX_HASH, LX_LINE, LX_BLOCK, LX_SIGN, LX_IDENT,
    LX_INT, LX_FRAC, LX_E, LX_ESIGN, LX_EXP, LX_STR, LX_STR_ESC
  } lex_mode_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] offset;
    logic [15:0] length;
    logic        last;
  } token_t;

  class token_scoreboard;
    lex_mode_e   mode;
    logic [1:0]  held_cnt;
    logic [31:0] tok_start;
    logic [31:0] pos;
    int          run_len;
    logic [7:0]  depth;
    logic [7:0]  prev;
    token_t      pending[$];
    token_t      byte_toks[$];
    int          errors;

    function void clear();
      mode = LX_IDLE;
      held_cnt = 0;
      tok_start = 0;
      pos = 0;
      run_len = 0;
      depth = 0;
      prev = 0;
    endfunction

    function void emit(logic [3:0] k, logic [31:0] o, int n);
      token_t t;
      if (byte_toks.size() >= MAX_TOKENS) return;
      t.kind = k;
      t.offset = o;
      t.length = (n > 65535) ? 16'hFFFF : n[15:0];
      t.last = 1'b0;
      byte_toks.push_back(t);
    endfunction

    function void grow(int n);
      run_len = (run_len + n > 65535) ? 65535 : run_len + n;
    endfunction

    function bit digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit blank(logic [7:0] b);
      return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0B || b == 8'h0C;
    endfunction

    function bit ident_stop(logic [7:0] b);
      return blank(b) || b == CH_NL || b == CH_LPAREN || b == CH_RPAREN ||
             b == CH_LBRACK || b == CH_RBRACK || b == CH_LBRACE ||
             b == CH_RBRACE || b == CH_BSL;
    endfunction

    // number ends before the exponent mark; held bytes open an identifier
    function void back_off(logic [31:0] nxt);
      emit(KIND_NUMBER, tok_start, run_len);
      tok_start = nxt - held_cnt;
      run_len = held_cnt;
      held_cnt = 0;
      mode = LX_IDENT;
    endfunction

    function void lex(logic [7:0] b, logic [31:0] p);
      while (1) begin
        case (mode)
          LX_IDLE: begin
            tok_start = p;
            run_len = 1;
            if (blank(b)) return;
            case (b)
              CH_BSL: mode = LX_BSL;
              CH_HASH: mode = LX_HASH;
              CH_NL: emit(KIND_STMT, p, 1);
              CH_LPAREN: emit(KIND_LPAREN, p, 1);
              CH_RPAREN: emit(KIND_RPAREN, p, 1);
              CH_LBRACK: emit(KIND_LBRACK, p, 1);
              CH_RBRACK: emit(KIND_RBRACK, p, 1);
              CH_LBRACE: emit(KIND_LBRACE, p, 1);
              CH_RBRACE: emit(KIND_RBRACE, p, 1);
              CH_BAR: emit(KIND_BAR, p, 1);
              CH_QUOTE: begin
                tok_start = p + 1;
                run_len = 0;
                mode = LX_STR;
              end
              CH_PLUS, CH_MINUS: mode = LX_SIGN;
              default: mode = digit(b) ? LX_INT : LX_IDENT;
            endcase
            return;
          end
          LX_BSL: begin
            mode = LX_IDLE;
            if (b == CH_NL) return;
            emit(KIND_INVALID, tok_start, 1);
          end
          LX_HASH: begin
            if (b == CH_LBRACK) begin
              mode = LX_BLOCK;
              depth = 1;
              prev = 0;
              grow(1);
            end else if (b == CH_NL) begin
              emit(KIND_STMT, p, 1);
              mode = LX_IDLE;
            end else begin
              mode = LX_LINE;
              grow(1);
            end
            return;
          end
          LX_LINE: begin
            if (b == CH_NL) begin
              emit(KIND_STMT, p, 1);
              mode = LX_IDLE;
            end else grow(1);
            return;
          end
          LX_BLOCK: begin
            grow(1);
            if (prev == CH_HASH && b == CH_LBRACK) begin
              if (depth != 8'hFF) depth++;
              prev = 0;
            end else if (prev == CH_RBRACK && b == CH_HASH) begin
              prev = 0;
              if (depth > 0) depth--;
              if (depth == 0) begin
                emit(KIND_STMT, p, 1);
                mode = LX_IDLE;
              end
            end else prev = b;
            return;
          end
          LX_SIGN: begin
            if (digit(b)) begin
              mode = LX_INT;
              grow(1);
              return;
            end
            mode = LX_IDENT;
          end
          LX_IDENT: begin
            if (!ident_stop(b)) begin
              grow(1);
              return;
            end
            emit(KIND_IDENT, tok_start, run_len);
            mode = LX_IDLE;
          end
          LX_INT, LX_FRAC, LX_EXP: begin
            if (digit(b)) begin
              grow(1);
              return;
            end
            if (mode == LX_INT && b == CH_DOT) begin
              mode = LX_FRAC;
              grow(1);
              return;
            end
            if (mode != LX_EXP && (b == CH_LOW_E || b == CH_UP_E)) begin
              held_cnt = 2'd1;
              mode = LX_E;
              return;
            end
            emit(KIND_NUMBER, tok_start, run_len);
            mode = LX_IDLE;
          end
          LX_E, LX_ESIGN: begin
            if (digit(b)) begin
              grow(held_cnt + 1);
              held_cnt = 0;
              mode = LX_EXP;
              return;
            end
            if (mode == LX_E && (b == CH_PLUS || b == CH_MINUS)) begin
              held_cnt++;
              mode = LX_ESIGN;
              return;
            end
            back_off(p);
          end
          LX_STR: begin
            if (b == CH_QUOTE) begin
              emit(KIND_STRING, tok_start, run_len);
              mode = LX_IDLE;
              return;
            end
            grow(1);
            if (b == CH_BSL) mode = LX_STR_ESC;
            return;
          end
          LX_STR_ESC: begin
            grow(1);
            mode = LX_STR;
            return;
          end
          default: mode = LX_IDLE;
        endcase
      end
    endfunction

    // closes whatever is open at the end of the text
    function void close_text(logic [31:0] q);
      case (mode)
        LX_BSL: emit(KIND_INVALID, tok_start, 1);
        LX_HASH, LX_LINE, LX_BLOCK: emit(KIND_INVALID, tok_start, run_len);
        LX_SIGN, LX_IDENT: emit(KIND_IDENT, tok_start, run_len);
        LX_INT, LX_FRAC, LX_EXP: emit(KIND_NUMBER, tok_start, run_len);
        LX_E, LX_ESIGN: begin
          back_off(q);
          emit(KIND_IDENT, tok_start, run_len);
        end
        default: ;
      endcase
      emit(KIND_END, q, 0);
      clear();
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      logic [31:0] p;
      p = pos;
      byte_toks.delete();
      lex(b, p);
      pos = p + 1;
      if (fin) close_text(p + 1);
      if (byte_toks.size() > 0) byte_toks[byte_toks.size()-1].last = 1'b1;
      foreach (byte_toks[i]) pending.push_back(byte_toks[i]);
    endfunction

    function void check(token_t got);
      token_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected token %h", got);
        return;
      end
      want = pending.pop_front();
      if (want != got) begin
        errors++;
        if (errors <= 10)
          $display("token mismatch: expected kind %0d off %0d len %0d last %0b, ",
                   want.kind, want.offset, want.length, want.last,
                   "got kind %0d off %0d len %0d last %0b",
                   got.kind, got.offset, got.length, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  text_byte = 8'h00;
  logic        final_byte = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  token_kind;
  logic [31:0] token_offset;
  logic [15:0] token_length;
  logic        last_of_run;
  logic        out_valid;
  logic        out_stall = 1'b0;

  token_scoreboard sb;
  bit          busy_phase;
  int          bytes_sent;
  logic [7:0]  text[$];

  script_byte_tokenizer i_dut (
    .clk(clk), .rst(rst), .text_byte(text_byte), .final_byte(final_byte),
    .in_valid(in_valid), .in_stall(in_stall), .token_kind(token_kind),
    .token_offset(token_offset), .token_length(token_length),
    .last_of_run(last_of_run), .out_valid(out_valid), .out_stall(out_stall)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4ms;
    $display("FAILURE");
    $finish;
  end

  always @(negedge clk) begin
    if (!rst) out_stall <= !busy_phase && ($urandom_range(99) < 20);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check('{token_kind, token_offset, token_length, last_of_run});
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while (!busy_phase && $urandom_range(99) < 20) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    text_byte = b;
    final_byte = fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && i == s.len() - 1);
  endtask

  task automatic send_queue();
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    text.delete();
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  task automatic push_digits();
    int n;
    n = $urandom_range(3, 1);
    repeat (n) text.push_back(8'("0" + $urandom_range(9)));
  endtask

  // one random lexeme, mostly well formed
  task automatic push_piece();
    int pick;
    pick = $urandom_range(13);
    case (pick)
      0, 1: begin
        repeat ($urandom_range(4, 1)) text.push_back(8'("a" + $urandom_range(25)));
      end
      2, 3: begin
        if ($urandom_range(1)) text.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        push_digits();
        if ($urandom_range(1)) begin
          text.push_back(CH_DOT);
          push_digits();
        end
        if ($urandom_range(2) != 0) begin
          text.push_back($urandom_range(1) ? CH_LOW_E : CH_UP_E);
          if ($urandom_range(1)) text.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
          if ($urandom_range(1)) push_digits();
        end
      end
      4: begin
        text.push_back(CH_QUOTE);
        repeat ($urandom_range(3)) text.push_back(8'("a" + $urandom_range(25)));
        if ($urandom_range(1)) push_str("\\\"");
        if ($urandom_range(4) != 0) text.push_back(CH_QUOTE);
      end
      5: push_str($urandom_range(1) ? "#ab\n" : "#\n");
      6: push_str($urandom_range(1) ? "#[x#[y]#z]#" : "#[a]]#");
      7: begin
        case ($urandom_range(7))
          0: text.push_back(CH_LPAREN);
          1: text.push_back(CH_RPAREN);
          2: text.push_back(CH_LBRACK);
          3: text.push_back(CH_RBRACK);
          4: text.push_back(CH_LBRACE);
          5: text.push_back(CH_RBRACE);
          6: text.push_back(CH_BAR);
          default: text.push_back(CH_NL);
        endcase
      end
      8, 9: begin
        case ($urandom_range(4))
          0: text.push_back(8'h09);
          1: text.push_back(8'h0D);
          2: text.push_back(8'h0B);
          3: text.push_back(8'h0C);
          default: text.push_back(8'h20);
        endcase
      end
      10: push_str($urandom_range(1) ? "\\\n" : "\\x");
      11: text.push_back(CH_NL);
      default: text.push_back(8'($urandom_range(255)));
    endcase
  endtask

  initial begin
    sb = new();
    sb.clear();
    sb.errors = 0;
    busy_phase = 1'b0;
    bytes_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: punctuation, numbers with back-off, strings, comments, end cases
    send_text("a(b)[]{}|\n", 1'b0);
    send_text("+1.5e-3 2E+x 7e", 1'b1);
    send_text("\"q\\\"\"\t\r\\\n\\y", 1'b1);
    send_text("#c\n#[1#[]#]#", 1'b0);
    send_text("#[z", 1'b1);
    send_text("\"u", 1'b1);
    send_text("-", 1'b1);
    send_text("\\", 1'b1);
    text.push_back(8'hFF);
    text.push_back(8'h80);
    text.push_back(8'h00);
    send_queue();

    while (bytes_sent < 220) begin
      busy_phase = (bytes_sent > 100 && bytes_sent < 160);
      repeat ($urandom_range(6, 1)) push_piece();
      send_queue();
    end
    busy_phase = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== script_byte_tokenizer.f =====
+incdir+hw/rtl
hw/rtl/stb_pkg.sv
hw/rtl/stb_front.sv
hw/rtl/stb_queue.sv
hw/rtl/stb_back.sv
hw/rtl/script_byte_tokenizer.sv
tb/tb_top.sv
